/* rtl/muwe_pkg.sv */
package muwe_pkg;

  localparam int unsigned DIM_W       = 7;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned RANK_W      = 15;
  localparam int unsigned PROD_W      = COORD_W + DIM_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_SLOT    = 24;
  localparam int unsigned NUM_CAND    = 12;
  localparam int unsigned MAX_DIM_DEF = 64;

  localparam logic [DIM_W-1:0] GRID_RESET = 7'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  // Candidate ranks around one doubled cell. S* are south-wall ranks (row-major),
  // E* are east-wall ranks (column-major plus offset). M/P mean one row or column
  // before/after the block, the trailing 1 means the second half of the block.
  typedef enum logic [3:0] {
    CAND_S0,
    CAND_S1,
    CAND_SM,
    CAND_SM1,
    CAND_SP,
    CAND_SP1,
    CAND_E0,
    CAND_E1,
    CAND_EM,
    CAND_EM1,
    CAND_EP,
    CAND_EP1
  } cand_t;

  // Fixed emission order: north rules, south rules, west rules, east rules,
  // then the center cross of a cell without walls.
  function automatic cand_t slot_cand(input int unsigned k);
    cand_t c;
    case (k)
      0:       c = CAND_SM;
      1:       c = CAND_SM1;
      2:       c = CAND_S0;
      3:       c = CAND_S1;
      4:       c = CAND_E1;
      5:       c = CAND_SP;
      6:       c = CAND_SP1;
      7:       c = CAND_S0;
      8:       c = CAND_S1;
      9:       c = CAND_E0;
      10:      c = CAND_EM;
      11:      c = CAND_EM1;
      12:      c = CAND_E0;
      13:      c = CAND_E1;
      14:      c = CAND_S1;
      15:      c = CAND_EP;
      16:      c = CAND_EP1;
      17:      c = CAND_E0;
      18:      c = CAND_E1;
      19:      c = CAND_S0;
      20:      c = CAND_E0;
      21:      c = CAND_S0;
      22:      c = CAND_E1;
      23:      c = CAND_S1;
      default: c = CAND_S0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/maze_unicursal_wall_expander_unit.sv */
// A start transfer passes through stage 1, stage 2, stage 3 and the emitter, and
// out_valid is registered behind the emitter.
// Throughput: a cell gives 1 to 8 results, one per cycle; the result emitter holds a cell
// until its last result is out, and the three arithmetic stages in front of it stall behind it.
// Cells with a single result therefore stream at one per cycle; busy rises while stalled.
// Reset (rst_n low, synchronous) empties every stage and sets the grid to 16 by 16.
module maze_unicursal_wall_expander_unit #(
  parameter int unsigned MAX_DIM = muwe_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [muwe_pkg::COORD_W-1:0]     in_cell_x,
  input  logic [muwe_pkg::COORD_W-1:0]     in_cell_y,
  input  logic                             in_wall_north,
  input  logic                             in_wall_east,
  input  logic                             in_wall_south,
  input  logic                             in_wall_west,
  output logic                             out_valid,
  output logic [muwe_pkg::RANK_W-1:0]      out_wall_rank,
  output logic                             out_has_write,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [muwe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [muwe_pkg::DIM_W-1:0]       cfg_data
);

  localparam int unsigned DW = muwe_pkg::DIM_W;
  localparam int unsigned CW = muwe_pkg::COORD_W;
  localparam int unsigned RW = muwe_pkg::RANK_W;
  localparam int unsigned PW = muwe_pkg::PROD_W;
  localparam int unsigned NS = muwe_pkg::NUM_SLOT;
  localparam int unsigned NC = muwe_pkg::NUM_CAND;

  // Configuration registers
  logic [DW-1:0] grid_width_r, grid_height_r;
  logic [DW-1:0] eff_wd, eff_ht;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= muwe_pkg::GRID_RESET;
      grid_height_r <= muwe_pkg::GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        muwe_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        muwe_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_wd = ({2'b00, grid_width_r} > 9'(MAX_DIM))  ? DW'(MAX_DIM) : grid_width_r;
    eff_ht = ({2'b00, grid_height_r} > 9'(MAX_DIM)) ? DW'(MAX_DIM) : grid_height_r;
  end

  // Pipeline flow control
  logic p1_valid_r, p2_valid_r, p3_valid_r, em_valid_r;
  logic em_free, p3_free, p2_free, p1_free, accept;
  logic em_none, em_done;
  logic [NS-1:0] em_mask_r, sel_onehot, mask_clr;

  assign em_free = !em_valid_r || em_done;
  assign p3_free = !p3_valid_r || em_free;
  assign p2_free = !p2_valid_r || p3_free;
  assign p1_free = !p1_valid_r || p2_free;
  assign busy    = !p1_free;
  assign accept  = start && p1_free;

  // Stage 1: captured cell and effective dimensions
  logic [CW-1:0] p1_x_r, p1_y_r;
  logic [3:0]    p1_walls_r;  // {north, east, south, west}
  logic [DW-1:0] p1_wd_r, p1_ht_r;

  // Stage 2: products and border flags
  logic [CW-1:0] p2_x_r, p2_y_r;
  logic [3:0]    p2_walls_r;
  logic [DW-1:0] p2_wd_r, p2_ht_r;
  logic [PW-1:0] p2_sy_r, p2_ex_r;
  logic [RW-1:0] p2_off_r;
  logic          p2_ig_r, p2_top_r, p2_bot_r, p2_lft_r, p2_rgt_r;
  logic [PW-1:0] sy_nxt, ex_nxt;
  logic [RW-1:0] off_nxt;
  logic [DW:0]   h2m1;
  logic          ig_nxt, top_nxt, bot_nxt, lft_nxt, rgt_nxt;

  always_comb begin
    sy_nxt  = PW'(p1_y_r) * PW'(p1_wd_r);
    ex_nxt  = PW'(p1_x_r) * PW'(p1_ht_r);
    h2m1    = {p1_ht_r, 1'b0} - (DW+1)'(1);
    off_nxt = RW'(p1_wd_r) * RW'(h2m1);
    ig_nxt  = ({1'b0, p1_x_r} < p1_wd_r) && ({1'b0, p1_y_r} < p1_ht_r);
    top_nxt = (p1_y_r == '0);
    bot_nxt = ({1'b0, p1_y_r} == (p1_ht_r - DW'(1)));
    lft_nxt = (p1_x_r == '0);
    rgt_nxt = ({1'b0, p1_x_r} == (p1_wd_r - DW'(1)));
  end

  // Stage 3: base ranks of the doubled block and the slot mask
  logic [RW-1:0] p3_s0_r, p3_e0_r, p3_w2_r, p3_h2_r;
  logic [NS-1:0] p3_mask_r;
  logic [RW-1:0] s0_nxt, e0_nxt;
  logic [NS-1:0] mask_nxt;
  logic          wn, we, ws, ww, ig;

  always_comb begin
    s0_nxt = RW'({p2_sy_r, 2'b00}) + RW'({p2_x_r, 1'b0});
    e0_nxt = RW'({p2_ex_r, 2'b00}) + RW'({p2_y_r, 1'b0}) + RW'({p2_off_r, 1'b0});
    {wn, we, ws, ww} = p2_walls_r;
    ig = p2_ig_r;
    mask_nxt[0]  = ig && wn && !p2_top_r;
    mask_nxt[1]  = ig && wn && !p2_top_r;
    mask_nxt[2]  = ig && wn && !ww;
    mask_nxt[3]  = ig && wn && !we;
    mask_nxt[4]  = ig && wn && !we && !ws && !ww;
    mask_nxt[5]  = ig && ws && !p2_bot_r;
    mask_nxt[6]  = ig && ws && !p2_bot_r;
    mask_nxt[7]  = ig && ws && !ww;
    mask_nxt[8]  = ig && ws && !we;
    mask_nxt[9]  = ig && ws && !wn && !we && !ww;
    mask_nxt[10] = ig && ww && !p2_lft_r;
    mask_nxt[11] = ig && ww && !p2_lft_r;
    mask_nxt[12] = ig && ww && !wn;
    mask_nxt[13] = ig && ww && !ws;
    mask_nxt[14] = ig && ww && !wn && !we && !ws;
    mask_nxt[15] = ig && we && !p2_rgt_r;
    mask_nxt[16] = ig && we && !p2_rgt_r;
    mask_nxt[17] = ig && we && !wn;
    mask_nxt[18] = ig && we && !ws;
    mask_nxt[19] = ig && we && !wn && !ws && !ww;
    for (int k = 20; k < 24; k++) begin
      mask_nxt[k] = ig && !wn && !we && !ws && !ww;
    end
  end

  // Emitter: candidate ranks and the slots still to send
  logic [RW-1:0] em_cand_r [NC];
  logic [RW-1:0] cand_nxt  [NC];
  logic [RW-1:0] rank_sel;

  always_comb begin
    cand_nxt[muwe_pkg::CAND_S0]  = p3_s0_r;
    cand_nxt[muwe_pkg::CAND_S1]  = p3_s0_r + RW'(1);
    cand_nxt[muwe_pkg::CAND_SM]  = p3_s0_r - p3_w2_r;
    cand_nxt[muwe_pkg::CAND_SM1] = p3_s0_r - p3_w2_r + RW'(1);
    cand_nxt[muwe_pkg::CAND_SP]  = p3_s0_r + p3_w2_r;
    cand_nxt[muwe_pkg::CAND_SP1] = p3_s0_r + p3_w2_r + RW'(1);
    cand_nxt[muwe_pkg::CAND_E0]  = p3_e0_r;
    cand_nxt[muwe_pkg::CAND_E1]  = p3_e0_r + RW'(1);
    cand_nxt[muwe_pkg::CAND_EM]  = p3_e0_r - p3_h2_r;
    cand_nxt[muwe_pkg::CAND_EM1] = p3_e0_r - p3_h2_r + RW'(1);
    cand_nxt[muwe_pkg::CAND_EP]  = p3_e0_r + p3_h2_r;
    cand_nxt[muwe_pkg::CAND_EP1] = p3_e0_r + p3_h2_r + RW'(1);
  end

  // The lowest pending slot goes out each cycle; an empty mask is the no-write result.
  always_comb begin
    sel_onehot = em_mask_r & (~em_mask_r + NS'(1));
    mask_clr   = em_mask_r & ~sel_onehot;
    em_none    = (em_mask_r == '0);
    em_done    = em_valid_r && (em_none || (mask_clr == '0));
    rank_sel   = '0;
    for (int unsigned k = 0; k < NS; k++) begin
      if (sel_onehot[k]) begin
        rank_sel = rank_sel | em_cand_r[muwe_pkg::slot_cand(k)];
      end
    end
  end

  // Output registers
  logic          out_valid_r, out_has_write_r, out_last_r;
  logic [RW-1:0] out_wall_rank_r;

  assign out_valid     = out_valid_r;
  assign out_wall_rank = out_wall_rank_r;
  assign out_has_write = out_has_write_r;
  assign out_last      = out_last_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      em_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_free) p1_valid_r <= accept;
      if (p2_free) p2_valid_r <= p1_valid_r;
      if (p3_free) p3_valid_r <= p2_valid_r;
      if (em_free) em_valid_r <= p3_valid_r;
      out_valid_r <= em_valid_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_x_r     <= in_cell_x;
      p1_y_r     <= in_cell_y;
      p1_walls_r <= {in_wall_north, in_wall_east, in_wall_south, in_wall_west};
      p1_wd_r    <= eff_wd;
      p1_ht_r    <= eff_ht;
    end
    if (p2_free) begin
      p2_x_r     <= p1_x_r;
      p2_y_r     <= p1_y_r;
      p2_walls_r <= p1_walls_r;
      p2_wd_r    <= p1_wd_r;
      p2_ht_r    <= p1_ht_r;
      p2_sy_r    <= sy_nxt;
      p2_ex_r    <= ex_nxt;
      p2_off_r   <= off_nxt;
      p2_ig_r    <= ig_nxt;
      p2_top_r   <= top_nxt;
      p2_bot_r   <= bot_nxt;
      p2_lft_r   <= lft_nxt;
      p2_rgt_r   <= rgt_nxt;
    end
    if (p3_free) begin
      p3_s0_r   <= s0_nxt;
      p3_e0_r   <= e0_nxt;
      p3_w2_r   <= RW'({p2_wd_r, 1'b0});
      p3_h2_r   <= RW'({p2_ht_r, 1'b0});
      p3_mask_r <= mask_nxt;
    end
    if (em_free) begin
      em_mask_r <= p3_mask_r;
      em_cand_r <= cand_nxt;
    end else begin
      em_mask_r <= mask_clr;
    end
    out_wall_rank_r <= em_none ? '0 : rank_sel;
    out_has_write_r <= !em_none;
    out_last_r      <= em_none || (mask_clr == '0);
  end

endmodule

/* rtl/muwe_checker.sv */
module muwe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [muwe_pkg::RANK_W-1:0]      out_wall_rank,
  input logic                             out_has_write,
  input logic                             out_last
);

  logic [2:0] run_cnt_r, run_cnt_nxt;
  logic [3:0] pend_r, pend_nxt;

  // Results since the last final one, and cells whose final result is still to come.
  always_comb begin
    run_cnt_nxt = run_cnt_r;
    if (out_valid) run_cnt_nxt = out_last ? 3'd0 : run_cnt_r + 3'd1;
    pend_nxt = pend_r + {3'd0, start && !busy} - {3'd0, out_valid && out_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
      pend_r    <= '0;
    end else begin
      run_cnt_r <= run_cnt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_no_write_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_write) |-> (out_last && out_wall_rank == '0))
    else $error("no-write result is not a lone zero final result");

  a_max_eight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && run_cnt_r == 3'd7) |-> out_last)
    else $error("more than eight results for one cell");

  a_last_has_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (pend_r != 4'd0))
    else $error("final result without an accepted cell");

  a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd5)
    else $error("more cells in flight than the pipeline holds");

endmodule

bind maze_unicursal_wall_expander_unit muwe_checker u_muwe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_wall_rank (out_wall_rank),
  .out_has_write (out_has_write),
  .out_last      (out_last)
);
